// ===== design/tbpbr_pkg.sv =====
// Shared types and constants for the two-button brightness ramp unit.
`default_nettype none

package tbpbr_pkg;

	localparam int CNT_W = 12;
	localparam int CFG_W = 12;
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [7:0] BRIGHT_MAX   = 8'd255;
	localparam logic [7:0] BRIGHT_MIN   = 8'd1;
	localparam logic [7:0] BRIGHT_RESET = 8'd128;

	localparam logic [CFG_W-1:0] LONG_TICKS_RESET   = CFG_W'(255);
	localparam logic [CFG_W-1:0] RAMP_TICKS_RESET   = CFG_W'(1 << 4);
	localparam logic [CFG_W-1:0] REPEAT_TICKS_RESET = CFG_W'(1 << 10);

	localparam logic [CFG_IDX_W-1:0] CFG_POWER_PRESENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS  = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_PRESS = 2'd1,
		PH_SHORT = 2'd2,
		PH_LONG  = 2'd3
	} phase_t;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_SHORT = 2'd1;
	localparam logic [1:0] EV_LONG  = 2'd2;

	typedef struct packed {
		logic power_pressed;
		logic mode_pressed;
	} in_word_t;

	typedef struct packed {
		logic       display_on;
		logic [7:0] brightness_level;
		logic [1:0] power_event;
		logic [1:0] mode_event;
		logic       mode_advance;
	} out_word_t;

	function automatic logic exceeds(input logic [CNT_W-1:0] elapsed,
			input logic [CFG_W-1:0] thr);
		exceeds = CMP_W'(elapsed) > CMP_W'(thr);
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== design/two_button_press_brightness_ramp_unit.sv =====
// The result word of an accepted word is registered and shows in the cycle after it is accepted.
// Throughput: one word per cycle while the result is taken; the output register frees in the cycle it is taken.
// All per-tick work is one pass of logic from button state to the result register.
// Reset: asynchronous, active low; all registers but the result word take their reset values,
// display on at brightness 128, both buttons idle and released.
`default_nettype none

module two_button_press_brightness_ramp_unit
	import tbpbr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_word_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_word_t                 out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	logic             power_present_q;
	logic [CFG_W-1:0] long_ticks_q;
	logic [CFG_W-1:0] ramp_ticks_q;
	logic [CFG_W-1:0] repeat_ticks_q;

	phase_t           p_phase_q, m_phase_q;
	logic [CNT_W-1:0] p_elapsed_q, m_elapsed_q;
	logic             ramp_up_q;
	logic             p_prev_q, m_prev_q;
	logic             disp_q;
	logic [7:0]       bright_q;

	phase_t           p_phase_d, m_phase_d;
	logic [CNT_W-1:0] p_elapsed_d, m_elapsed_d;
	logic             ramp_up_d;
	logic             disp_d;
	logic [7:0]       bright_d;
	out_word_t        res_d;

	logic accept;

	assign in_ready = !out_valid || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		p_phase_d   = p_phase_q;
		m_phase_d   = m_phase_q;
		p_elapsed_d = p_elapsed_q;
		m_elapsed_d = m_elapsed_q;
		ramp_up_d   = ramp_up_q;
		disp_d      = disp_q;
		bright_d    = bright_q;
		res_d       = '0;

		// edge detection
		if (power_present_q) begin
			if (in_data.power_pressed != p_prev_q) begin
				if (in_data.power_pressed) begin
					p_elapsed_d = '0;
					p_phase_d   = PH_PRESS;
				end else begin
					p_phase_d = (p_phase_q == PH_PRESS) ? PH_SHORT : PH_IDLE;
				end
			end
		end else begin
			p_phase_d = PH_IDLE;
		end
		if (in_data.mode_pressed != m_prev_q) begin
			if (in_data.mode_pressed) begin
				m_elapsed_d = '0;
				m_phase_d   = PH_PRESS;
			end else begin
				m_phase_d = (m_phase_q == PH_PRESS) ? PH_SHORT : PH_IDLE;
			end
		end

		// power handler
		if (power_present_q) begin
			if (p_phase_d == PH_SHORT) begin
				p_phase_d         = PH_IDLE;
				disp_d            = !disp_d;
				res_d.power_event = EV_SHORT;
			end else if (p_phase_d == PH_PRESS && exceeds(p_elapsed_d, long_ticks_q)) begin
				p_phase_d         = PH_LONG;
				res_d.power_event = EV_LONG;
				if (!disp_d) begin
					p_elapsed_d = '0;
					ramp_up_d   = 1'b1;
					bright_d    = BRIGHT_MIN;
					disp_d      = 1'b1;
				end else if (bright_d == BRIGHT_MAX) begin
					ramp_up_d = 1'b0;
				end else if (bright_d <= BRIGHT_MIN) begin
					ramp_up_d = 1'b1;
				end else begin
					ramp_up_d = !ramp_up_d;
				end
			end else if (p_phase_d == PH_LONG && exceeds(p_elapsed_d, ramp_ticks_q)) begin
				p_elapsed_d = '0;
				if (ramp_up_d && bright_d < BRIGHT_MAX) begin
					bright_d = bright_d + 8'd1;
					disp_d   = 1'b1;
				end else if (!ramp_up_d && bright_d > BRIGHT_MIN) begin
					bright_d = bright_d - 8'd1;
					disp_d   = 1'b1;
				end
			end
		end

		// mode handler
		if (m_phase_d == PH_SHORT) begin
			m_phase_d = PH_IDLE;
			if (power_present_q) begin
				res_d.mode_advance = 1'b1;
			end else begin
				disp_d = !disp_d;
			end
			res_d.mode_event = EV_SHORT;
		end else if (m_phase_d == PH_PRESS && exceeds(m_elapsed_d, long_ticks_q)) begin
			m_phase_d        = PH_LONG;
			res_d.mode_event = EV_LONG;
			if (!disp_d) begin
				m_elapsed_d = '0;
				disp_d      = 1'b1;
			end
		end else if (m_phase_d == PH_LONG && exceeds(m_elapsed_d, repeat_ticks_q)) begin
			m_elapsed_d        = '0;
			res_d.mode_advance = 1'b1;
		end

		p_elapsed_d = sat_inc(p_elapsed_d);
		m_elapsed_d = sat_inc(m_elapsed_d);

		res_d.display_on       = disp_d;
		res_d.brightness_level = bright_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_present_q <= 1'b1;
			long_ticks_q    <= LONG_TICKS_RESET;
			ramp_ticks_q    <= RAMP_TICKS_RESET;
			repeat_ticks_q  <= REPEAT_TICKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POWER_PRESENT: power_present_q <= cfg_wdata[0];
				CFG_LONG_TICKS:    long_ticks_q    <= cfg_wdata;
				CFG_RAMP_TICKS:    ramp_ticks_q    <= cfg_wdata;
				CFG_REPEAT_TICKS:  repeat_ticks_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_phase_q   <= PH_IDLE;
			m_phase_q   <= PH_IDLE;
			p_elapsed_q <= '0;
			m_elapsed_q <= '0;
			ramp_up_q   <= 1'b0;
			p_prev_q    <= 1'b0;
			m_prev_q    <= 1'b0;
			disp_q      <= 1'b1;
			bright_q    <= BRIGHT_RESET;
		end else if (accept) begin
			p_phase_q   <= p_phase_d;
			m_phase_q   <= m_phase_d;
			p_elapsed_q <= p_elapsed_d;
			m_elapsed_q <= m_elapsed_d;
			ramp_up_q   <= ramp_up_d;
			p_prev_q    <= in_data.power_pressed;
			m_prev_q    <= in_data.mode_pressed;
			disp_q      <= disp_d;
			bright_q    <= bright_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data <= res_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/tbpbr_checker.sv =====
// Port-level checker for the two-button brightness ramp unit, with its bind.
`default_nettype none

module tbpbr_checker
	import tbpbr_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire in_word_t             in_data,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire out_word_t            out_data,
	input wire logic                 cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0]     cfg_wdata
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// every accepted word yields a result on the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after accepted word");

	a_bright_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.brightness_level != 8'd0)
		else $error("brightness left its range");

	// entering a long press always leaves the display on
	a_long_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.power_event == EV_LONG || out_data.mode_event == EV_LONG)
		|-> out_data.display_on)
		else $error("long press left display off");

endmodule

bind two_button_press_brightness_ramp_unit tbpbr_checker u_tbpbr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_wdata (cfg_wdata)
);

`default_nettype wire

// ===== bench/two_button_press_brightness_ramp_unit_tb.sv =====
// Self-checking bench for the two-button press classifier and brightness ramp unit.
`default_nettype none

module two_button_press_brightness_ramp_unit_tb;
	import tbpbr_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;

	class panel_tracker;
		logic                 power_fitted;
		logic [CFG_W-1:0]     long_thr;
		logic [CFG_W-1:0]     ramp_thr;
		logic [CFG_W-1:0]     repeat_thr;
		phase_t               pwr_ph;
		phase_t               mode_ph;
		logic [CNT_W-1:0]     pwr_cnt;
		logic [CNT_W-1:0]     mode_cnt;
		logic                 ramp_rising;
		logic                 pwr_last;
		logic                 mode_last;
		logic                 disp;
		logic [7:0]           bright;
		out_word_t            due_words[$];
		int                   errors;

		function new();
			power_fitted = 1'b1;
			long_thr = LONG_TICKS_RESET;
			ramp_thr = RAMP_TICKS_RESET;
			repeat_thr = REPEAT_TICKS_RESET;
			pwr_ph = PH_IDLE;
			mode_ph = PH_IDLE;
			pwr_cnt = '0;
			mode_cnt = '0;
			ramp_rising = 1'b0;
			pwr_last = 1'b0;
			mode_last = 1'b0;
			disp = 1'b1;
			bright = BRIGHT_RESET;
			errors = 0;
		endfunction

		function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
			case (idx)
				CFG_POWER_PRESENT: power_fitted = val[0];
				CFG_LONG_TICKS:    long_thr = val;
				CFG_RAMP_TICKS:    ramp_thr = val;
				CFG_REPEAT_TICKS:  repeat_thr = val;
				default: ;
			endcase
		endfunction

		function void track_edge(input logic lvl, inout logic last, inout phase_t ph,
				inout logic [CNT_W-1:0] cnt);
			if (lvl != last) begin
				if (lvl) begin
					cnt = '0;
					ph = PH_PRESS;
				end else begin
					ph = (ph == PH_PRESS) ? PH_SHORT : PH_IDLE;
				end
			end
			last = lvl;
		endfunction

		function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
			return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
		endfunction

		function void note_tick(input in_word_t w);
			out_word_t  r;
			logic [1:0] pev;
			logic [1:0] mev;
			logic       adv;
			pev = EV_NONE;
			mev = EV_NONE;
			adv = 1'b0;
			if (power_fitted) begin
				track_edge(w.power_pressed, pwr_last, pwr_ph, pwr_cnt);
			end else begin
				pwr_last = w.power_pressed;
				pwr_ph = PH_IDLE;
			end
			track_edge(w.mode_pressed, mode_last, mode_ph, mode_cnt);

			if (power_fitted) begin
				if (pwr_ph == PH_SHORT) begin
					pwr_ph = PH_IDLE;
					disp = !disp;
					pev = EV_SHORT;
				end else if (pwr_ph == PH_PRESS && pwr_cnt > long_thr) begin
					pwr_ph = PH_LONG;
					pev = EV_LONG;
					if (!disp) begin
						pwr_cnt = '0;
						ramp_rising = 1'b1;
						bright = BRIGHT_MIN;
						disp = 1'b1;
					end else if (bright == BRIGHT_MAX) begin
						ramp_rising = 1'b0;
					end else if (bright <= BRIGHT_MIN) begin
						ramp_rising = 1'b1;
					end else begin
						ramp_rising = !ramp_rising;
					end
				end else if (pwr_ph == PH_LONG && pwr_cnt > ramp_thr) begin
					pwr_cnt = '0;
					if (ramp_rising && bright < BRIGHT_MAX) begin
						bright = bright + 1'b1;
						disp = 1'b1;
					end else if (!ramp_rising && bright > BRIGHT_MIN) begin
						bright = bright - 1'b1;
						disp = 1'b1;
					end
				end
			end

			if (mode_ph == PH_SHORT) begin
				mode_ph = PH_IDLE;
				if (power_fitted)
					adv = 1'b1;
				else
					disp = !disp;
				mev = EV_SHORT;
			end else if (mode_ph == PH_PRESS && mode_cnt > long_thr) begin
				mode_ph = PH_LONG;
				mev = EV_LONG;
				if (!disp) begin
					mode_cnt = '0;
					disp = 1'b1;
				end
			end else if (mode_ph == PH_LONG && mode_cnt > repeat_thr) begin
				mode_cnt = '0;
				adv = 1'b1;
			end

			pwr_cnt = bump(pwr_cnt);
			mode_cnt = bump(mode_cnt);

			r.display_on = disp;
			r.brightness_level = bright;
			r.power_event = pev;
			r.mode_event = mev;
			r.mode_advance = adv;
			due_words.push_back(r);
		endfunction

		function void check_word(input out_word_t got);
			out_word_t exp;
			if (due_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word %h", got);
				return;
			end
			exp = due_words.pop_front();
			if (got !== exp) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch (exp/got): display_on %0d/%0d brightness %0d/%0d ",
						"power_event %0d/%0d mode_event %0d/%0d mode_advance %0d/%0d"},
						exp.display_on, got.display_on,
						exp.brightness_level, got.brightness_level,
						exp.power_event, got.power_event,
						exp.mode_event, got.mode_event,
						exp.mode_advance, got.mode_advance);
			end
		endfunction

		function int pending();
			return due_words.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_word_t             in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_word_t            out_data;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	panel_tracker sb;
	bit           calm;
	int           idle_odds;
	int           stall_odds;
	int           stall_left;
	int           sent;
	int           cycles;

	two_button_press_brightness_ramp_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_word(out_data);
		if (in_valid && in_ready)
			sb.note_tick(in_data);
	end

	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left = stall_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			stall_left = $urandom_range(0, 10);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic send_word(input logic p, input logic m);
		in_word_t w;
		int       gap;
		w.power_pressed = p;
		w.mode_pressed = m;
		@(negedge clk);
		if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic hold(input logic p, input logic m, input int n);
		repeat (n) send_word(p, m);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
	endtask

	task automatic program_regs(input logic present, input logic [CFG_W-1:0] lng,
			input logic [CFG_W-1:0] rmp, input logic [CFG_W-1:0] rpt);
		write_reg(CFG_POWER_PRESENT, CFG_W'(present));
		write_reg(CFG_LONG_TICKS, lng);
		write_reg(CFG_RAMP_TICKS, rmp);
		write_reg(CFG_REPEAT_TICKS, rpt);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_segment();
		int   kind;
		int   lng;
		int   n;
		logic p;
		logic m;
		kind = $urandom_range(0, 23);
		lng = int'(sb.long_thr);
		if (kind == 0) begin
			n = $urandom_range(1, 10);
			repeat (n) send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else if (kind == 1) begin
			// long hold; pins brightness at a limit when steps are fast
			hold(1'b1, 1'b0, $urandom_range(130, 160));
			hold(1'b0, 1'b0, $urandom_range(1, 3));
		end else begin
			case ($urandom_range(0, 2))
				0: {p, m} = 2'b10;
				1: {p, m} = 2'b01;
				default: {p, m} = 2'b11;
			endcase
			case ($urandom_range(0, 2))
				0: n = $urandom_range(1, (lng < 1) ? 1 : lng);
				1: n = lng + $urandom_range(0, 2);
				default: n = lng + 1 + $urandom_range(0,
					4 * int'(sb.ramp_thr) + 4 * int'(sb.repeat_thr) + 8);
			endcase
			if (n < 1)
				n = 1;
			hold(p, m, n);
			hold(1'b0, 1'b0, $urandom_range(1, 4));
		end
	endtask

	function automatic int pick_odds();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 3;
			default: return 8;
		endcase
	endfunction

	initial begin
		int ph;
		int stop_at;
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_POWER_PRESENT;
		cfg_wdata = '0;
		calm = 1'b0;
		idle_odds = 4;
		stall_odds = 4;
		stall_left = 0;
		sent = 0;
		cycles = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// short presses on each button and on both at once
		hold(1'b1, 1'b0, 1);
		hold(1'b0, 1'b0, 1);
		hold(1'b0, 1'b1, 1);
		hold(1'b0, 1'b0, 1);
		hold(1'b1, 1'b1, 1);
		hold(1'b0, 1'b0, 1);
		settle();

		// long presses: ramp with display on, ramp from dark, mode repeat
		program_regs(1'b1, CFG_W'(2), CFG_W'(0), CFG_W'(1));
		hold(1'b1, 1'b0, 5);
		hold(1'b0, 1'b0, 1);
		hold(1'b1, 1'b0, 1);
		hold(1'b0, 1'b0, 1);
		hold(1'b1, 1'b0, 4);
		hold(1'b0, 1'b0, 1);
		hold(1'b0, 1'b1, 5);
		hold(1'b0, 1'b0, 1);
		settle();

		// no power button: mode short toggles, mode long wakes, power ignored
		program_regs(1'b0, CFG_W'(1), CFG_W'(0), CFG_W'(0));
		hold(1'b0, 1'b1, 1);
		hold(1'b0, 1'b0, 1);
		hold(1'b0, 1'b1, 3);
		hold(1'b0, 1'b0, 1);
		hold(1'b1, 1'b0, 2);
		hold(1'b0, 1'b0, 1);

		for (ph = 0; ph < 12; ph++) begin
			settle();
			calm = (ph >= 10);
			idle_odds = pick_odds();
			stall_odds = pick_odds();
			if (ph == 3) begin
				// thresholds at counter max are never exceeded
				program_regs(1'b1, CNT_MAX, CNT_MAX, CNT_MAX);
				hold(1'b1, 1'b1, 30);
				hold(1'b0, 1'b0, 2);
			end else if (ph == 7) begin
				program_regs(1'b1, CFG_W'(4000), CFG_W'(4000), CFG_W'(4000));
				hold(1'b1, 1'b1, 30);
				hold(1'b0, 1'b0, 2);
			end else begin
				if (ph == 8)
					program_regs(1'b1, '0, '0, '0);
				else
					program_regs($urandom_range(0, 3) != 0, CFG_W'($urandom_range(0, 10)),
						CFG_W'($urandom_range(0, 3)), CFG_W'($urandom_range(0, 6)));
				stop_at = sent + 15;
				while (sent < stop_at)
					random_segment();
			end
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
